// File: src/rgbled_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared constants for the rgb led effect generator
// used by the channel interfaces and the top level; depends on nothing

package rgbled_pkg;

  localparam int NOW_MS_W      = 32;
  localparam int LED_W         = 8;
  localparam int TIME_BITS_DEF = 32;

  // register map, index = paddr[4:2]
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_BASE_RED   = 3'd0;
  localparam logic [2:0] REG_BASE_GREEN = 3'd1;
  localparam logic [2:0] REG_BASE_BLUE  = 3'd2;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd3;
  localparam logic [2:0] REG_MODE       = 3'd4;
  localparam logic [2:0] REG_ENABLE     = 3'd5;

  localparam logic [1:0] MODE_SOLID     = 2'd0;
  localparam logic [1:0] MODE_HUE_SWEEP = 2'd1;
  localparam logic [1:0] MODE_BREATH    = 2'd2;

  localparam logic [5:0] FRAME_MS  = 6'd30;
  localparam logic [8:0] HUE_STEP  = 9'd2;
  localparam logic [8:0] HUE_FULL  = 9'd360;
  localparam logic [8:0] HUE_SECT  = 9'd60;

  localparam logic [11:0] BREATH_PERIOD = 12'd3000;
  localparam logic [11:0] BREATH_HALF   = 12'd1500;
  localparam logic [14:0] BREATH_BASE   = 15'd4500;

  // floor(x / d) == (x * RECIP) >> SHIFT, exact over the operand ranges used here
  localparam logic [31:0] PCT_RECIP    = 32'd41944;      // d = 100, x < 2^15
  localparam int          PCT_SHIFT    = 22;
  localparam logic [31:0] MOD_RECIP    = 32'd2932031008; // d = 3000, x < 2^32
  localparam int          MOD_SHIFT    = 43;
  localparam logic [31:0] BREATH_RECIP = 32'd1501199876; // d = 3000000, x < 2^30
  localparam int          BREATH_SHIFT = 52;

endpackage

`default_nettype wire

// File: src/rgbled_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// tick channel: valid/ready handshake carrying the millisecond time
// depends on rgbled_pkg

interface rgbled_in_if
  import rgbled_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [NOW_MS_W-1:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

`default_nettype wire

// File: src/rgbled_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// led color channel: valid/ready handshake carrying the three led levels
// depends on rgbled_pkg

interface rgbled_out_if
  import rgbled_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [LED_W-1:0] led_red;
  logic [LED_W-1:0] led_green;
  logic [LED_W-1:0] led_blue;

  modport source (output valid, output led_red, output led_green, output led_blue,
                  input ready);
  modport sink   (input valid, input led_red, input led_green, input led_blue,
                  output ready);
endinterface

`default_nettype wire

// File: src/rgb_led_effect_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// rgb led effect generator: static, rainbow and breathing color from millisecond ticks
// depends on rgbled_pkg, rgbled_in_if, rgbled_out_if

// Each tick on in_ch carries the current millisecond time and yields zero or one led
// color on out_ch. All products go through one shared 32x32 multiplier with a registered
// result, stepped by a small sequencer, and in_ch.ready is high only while that sequencer
// is idle. A tick that yields nothing leaves the sequencer idle; a dark color goes from
// accept straight to output; a static or rainbow color takes two multiplier passes and a
// finish step for each of three channels, plus accept and output; a breathing color first
// reduces the time modulo 3000 with two passes and a step, then four steps per channel.
// A finished color sits in the output register, so the next tick can be taken while it
// waits; the output step stalls while that register is still held. Registers are written
// over the APB port at byte address 4*i and should be written only while the block is idle.

module rgb_led_effect_generator
  import rgbled_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rgbled_in_if.sink                  in_ch,
  rgbled_out_if.source               out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  localparam int NOW_BITS = (TIME_BITS < NOW_MS_W) ? TIME_BITS : NOW_MS_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BQ   = 4'd1;
  localparam logic [3:0] S_BP   = 4'd2;
  localparam logic [3:0] S_BT   = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // integer hsv with full saturation and value; ramps are f*255/60 = f*17/4
  function automatic rgb_t hue_color(input logic [8:0] hue);
    logic [2:0] sect;
    logic [8:0] f9;
    logic [5:0] f;
    logic [9:0] up_x;
    logic [9:0] dn_x;
    logic [7:0] up;
    logic [7:0] dn;
    rgb_t       c;
    sect = 3'd5;
    f9   = hue - 9'(5 * HUE_SECT);
    priority if (hue < HUE_SECT) begin
      sect = 3'd0;
      f9   = hue;
    end else if (hue < 9'(2 * HUE_SECT)) begin
      sect = 3'd1;
      f9   = hue - HUE_SECT;
    end else if (hue < 9'(3 * HUE_SECT)) begin
      sect = 3'd2;
      f9   = hue - 9'(2 * HUE_SECT);
    end else if (hue < 9'(4 * HUE_SECT)) begin
      sect = 3'd3;
      f9   = hue - 9'(3 * HUE_SECT);
    end else if (hue < 9'(5 * HUE_SECT)) begin
      sect = 3'd4;
      f9   = hue - 9'(4 * HUE_SECT);
    end else begin
      sect = 3'd5;
    end
    f    = f9[5:0];
    up_x = ({4'b0, f} << 4) + {4'b0, f};
    dn_x = ({4'b0, 6'(HUE_SECT) - f} << 4) + {4'b0, 6'(HUE_SECT) - f};
    up   = up_x[9:2];
    dn   = dn_x[9:2];
    unique case (sect)
      3'd0:    c = '{r: 8'hFF, g: up,    b: 8'h00};
      3'd1:    c = '{r: dn,    g: 8'hFF, b: 8'h00};
      3'd2:    c = '{r: 8'h00, g: 8'hFF, b: up};
      3'd3:    c = '{r: 8'h00, g: dn,    b: 8'hFF};
      3'd4:    c = '{r: up,    g: 8'h00, b: 8'hFF};
      default: c = '{r: 8'hFF, g: 8'h00, b: dn};
    endcase
    return c;
  endfunction

  // control state
  logic [3:0]           state_r, state_nxt;
  logic [1:0]           ch_r, ch_nxt;
  logic                 breath_r, breath_nxt;
  logic                 pending_r, pending_nxt;
  logic [8:0]           hue_r, hue_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           base_red_r, base_red_nxt;
  logic [7:0]           base_green_r, base_green_nxt;
  logic [7:0]           base_blue_r, base_blue_nxt;
  logic [6:0]           pct_r, pct_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic                 enable_r, enable_nxt;

  // datapath
  logic [NOW_BITS-1:0]  now_r, now_nxt;
  logic [14:0]          lvl_r, lvl_nxt;
  logic [63:0]          prod_r, prod_nxt;
  logic [7:0]           res_red_r, res_red_nxt;
  logic [7:0]           res_green_r, res_green_nxt;
  logic [7:0]           res_blue_r, res_blue_nxt;
  logic [7:0]           out_red_r, out_red_nxt;
  logic [7:0]           out_green_r, out_green_nxt;
  logic [7:0]           out_blue_r, out_blue_nxt;

  logic                 in_acc;
  logic                 cfg_wr;
  logic                 animated;
  logic [NOW_BITS-1:0]  now_w;
  logic [TIME_BITS-1:0] elapsed;
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic                 mul_en;
  rgb_t                 hue_rgb;
  logic [7:0]           ch_src;
  logic [8:0]           fin_raw;
  logic [7:0]           fin_val;
  logic [31:0]          mod_diff;
  logic [11:0]          mod_p;
  logic [10:0]          tri_v;
  logic [8:0]           hue_inc;
  logic                 out_free;

  assign pready       = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_wr       = psel && penable && pwrite;
  assign animated     = enable_r && (mode_r == MODE_HUE_SWEEP || mode_r == MODE_BREATH);
  assign now_w        = in_ch.now_ms[NOW_BITS-1:0];
  assign elapsed      = TIME_BITS'(now_w) - last_r;
  assign hue_rgb      = hue_color(hue_r);
  assign hue_inc      = hue_r + HUE_STEP;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.led_red   = out_red_r;
  assign out_ch.led_green = out_green_r;
  assign out_ch.led_blue  = out_blue_r;

  // time mod 3000 from the quotient product, then the triangle wave
  assign mod_diff = 32'(now_r) - prod_r[31:0];
  assign mod_p    = mod_diff[11:0];
  assign tri_v    = (mod_p < BREATH_HALF) ? mod_p[10:0] : 11'(BREATH_PERIOD - mod_p);

  always_comb begin
    unique case (ch_r)
      2'd0:    ch_src = (mode_r == MODE_HUE_SWEEP && !breath_r && animated) ? hue_rgb.r
                                                                             : base_red_r;
      2'd1:    ch_src = (mode_r == MODE_HUE_SWEEP && !breath_r && animated) ? hue_rgb.g
                                                                             : base_green_r;
      default: ch_src = (mode_r == MODE_HUE_SWEEP && !breath_r && animated) ? hue_rgb.b
                                                                             : base_blue_r;
    endcase
  end

  assign fin_raw = breath_r ? prod_r[BREATH_SHIFT+8:BREATH_SHIFT]
                            : prod_r[PCT_SHIFT+8:PCT_SHIFT];
  assign fin_val = (fin_raw > 9'd255) ? 8'hFF : fin_raw[7:0];

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_r)
      S_BQ: begin
        mul_a = 32'(now_r);
        mul_b = MOD_RECIP;
      end
      S_BP: begin
        mul_a = 32'(prod_r[63:MOD_SHIFT]);
        mul_b = 32'(BREATH_PERIOD);
      end
      S_M1: begin
        mul_a = 32'(ch_src);
        mul_b = 32'(pct_r);
      end
      S_M2: begin
        mul_a = 32'(prod_r[14:0]);
        mul_b = breath_r ? 32'(lvl_r) : PCT_RECIP;
      end
      S_M3: begin
        mul_a = 32'(prod_r[29:0]);
        mul_b = BREATH_RECIP;
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod_nxt = mul_en ? ({32'b0, mul_a} * {32'b0, mul_b}) : prod_r;

  always_comb begin
    state_nxt      = state_r;
    ch_nxt         = ch_r;
    breath_nxt     = breath_r;
    pending_nxt    = pending_r;
    hue_nxt        = hue_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r;
    base_red_nxt   = base_red_r;
    base_green_nxt = base_green_r;
    base_blue_nxt  = base_blue_r;
    pct_nxt        = pct_r;
    mode_nxt       = mode_r;
    enable_nxt     = enable_r;
    now_nxt        = now_r;
    lvl_nxt        = lvl_r;
    res_red_nxt    = res_red_r;
    res_green_nxt  = res_green_r;
    res_blue_nxt   = res_blue_r;
    out_red_nxt    = out_red_r;
    out_green_nxt  = out_green_r;
    out_blue_nxt   = out_blue_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          now_nxt = now_w;
          ch_nxt  = 2'd0;
          if (!animated) begin
            if (pending_r) begin
              pending_nxt = 1'b0;
              breath_nxt  = 1'b0;
              if (enable_r) begin
                state_nxt = S_M1;
              end else begin
                res_red_nxt   = 8'h00;
                res_green_nxt = 8'h00;
                res_blue_nxt  = 8'h00;
                state_nxt     = S_OUT;
              end
            end
          end else if (elapsed >= TIME_BITS'(FRAME_MS)) begin
            last_nxt = TIME_BITS'(now_w);
            if (mode_r == MODE_HUE_SWEEP) begin
              breath_nxt = 1'b0;
              hue_nxt    = (hue_inc >= HUE_FULL) ? hue_inc - HUE_FULL : hue_inc;
              state_nxt  = S_M1;
            end else begin
              breath_nxt = 1'b1;
              state_nxt  = S_BQ;
            end
          end
        end
      end
      S_BQ: state_nxt = S_BP;
      S_BP: state_nxt = S_BT;
      S_BT: begin
        lvl_nxt   = BREATH_BASE + ({4'b0, tri_v} << 4) + {4'b0, tri_v};
        state_nxt = S_M1;
      end
      S_M1: state_nxt = S_M2;
      S_M2: state_nxt = breath_r ? S_M3 : S_FIN;
      S_M3: state_nxt = S_FIN;
      S_FIN: begin
        unique case (ch_r)
          2'd0:    res_red_nxt   = fin_val;
          2'd1:    res_green_nxt = fin_val;
          default: res_blue_nxt  = fin_val;
        endcase
        if (ch_r == 2'd2) begin
          state_nxt = S_OUT;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = S_M1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_red_nxt   = res_red_r;
          out_green_nxt = res_green_r;
          out_blue_nxt  = res_blue_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_BASE_RED: begin
          base_red_nxt = pwdata[7:0];
          pending_nxt  = 1'b1;
        end
        REG_BASE_GREEN: begin
          base_green_nxt = pwdata[7:0];
          pending_nxt    = 1'b1;
        end
        REG_BASE_BLUE: begin
          base_blue_nxt = pwdata[7:0];
          pending_nxt   = 1'b1;
        end
        REG_BRIGHTNESS: begin
          pct_nxt     = pwdata[6:0];
          pending_nxt = 1'b1;
        end
        REG_MODE: begin
          mode_nxt    = pwdata[1:0];
          pending_nxt = 1'b1;
          if (pwdata[1:0] == MODE_HUE_SWEEP) begin
            hue_nxt = '0;
          end
        end
        REG_ENABLE: begin
          enable_nxt  = pwdata[0];
          pending_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_BASE_RED:   prdata = {24'b0, base_red_r};
      REG_BASE_GREEN: prdata = {24'b0, base_green_r};
      REG_BASE_BLUE:  prdata = {24'b0, base_blue_r};
      REG_BRIGHTNESS: prdata = {25'b0, pct_r};
      REG_MODE:       prdata = {30'b0, mode_r};
      REG_ENABLE:     prdata = {31'b0, enable_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ch_r         <= 2'd0;
      breath_r     <= 1'b0;
      pending_r    <= 1'b1;
      hue_r        <= '0;
      last_r       <= '0;
      out_valid_r  <= 1'b0;
      base_red_r   <= 8'd255;
      base_green_r <= 8'd255;
      base_blue_r  <= 8'd255;
      pct_r        <= 7'd100;
      mode_r       <= MODE_SOLID;
      enable_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ch_r         <= ch_nxt;
      breath_r     <= breath_nxt;
      pending_r    <= pending_nxt;
      hue_r        <= hue_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
      base_red_r   <= base_red_nxt;
      base_green_r <= base_green_nxt;
      base_blue_r  <= base_blue_nxt;
      pct_r        <= pct_nxt;
      mode_r       <= mode_nxt;
      enable_r     <= enable_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    lvl_r       <= lvl_nxt;
    prod_r      <= prod_nxt;
    res_red_r   <= res_red_nxt;
    res_green_r <= res_green_nxt;
    res_blue_r  <= res_blue_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

  // hue stays even and inside one turn
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    !hue_r[0] && hue_r < HUE_FULL)
    else $error("hue out of range");

  // channel counter only walks red, green, blue
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r != 2'd3)
    else $error("channel counter out of range");

  // a finished color lands in the output register once it is free
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded into output register");

  // a pending static or dark color is consumed by the transaction that sends it
  a_pending_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !animated && pending_r && !cfg_wr) |=> (!pending_r && state_r != S_IDLE))
    else $error("pending color not consumed");

  // breathing runs through the modulo steps before the channel loop
  a_breath_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BQ) |=> (state_r == S_BP) ##1 (state_r == S_BT))
    else $error("breathing sequence broken");

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// self-checking bench for rgb_led_effect_generator: drives millisecond ticks and apb
// register writes, predicts every led color and checks it; needs rgbled_pkg and both channel
// interfaces

module tb;
  import rgbled_pkg::*;

  localparam logic [1:0] MODE_SPARE   = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned SRC_PCT [4]    = '{0, 70, 0, 9};
  localparam int unsigned SNK_PCT [4]    = '{0, 0, 70, 9};

  typedef logic [2:0][LED_W-1:0] rgb_t;  // [0] red, [1] green, [2] blue

  // tracks register and effect state, holds the colors still owed by the block
  class led_color_board;
    bit [7:0]  base_r, base_g, base_b;
    bit [6:0]  pct;
    bit [1:0]  mode;
    bit        lit;
    bit [31:0] last_ms;
    bit [8:0]  hue;
    bit        pending;
    rgb_t      colors_due[$];
    int unsigned mismatches, checked, n_rainbow, n_breath, n_static;

    function new();
      base_r  = 8'd255;
      base_g  = 8'd255;
      base_b  = 8'd255;
      pct     = 7'd100;
      mode    = MODE_SOLID;
      lit     = 1'b0;
      last_ms = '0;
      hue     = '0;
      pending = 1'b1;
    endfunction

    function bit [7:0] clip(longint unsigned v);
      return (v > 64'd255) ? 8'd255 : v[7:0];
    endfunction

    function bit [7:0] dim(bit [7:0] c);
      return clip(64'(c) * 64'(pct) / 64'd100);
    endfunction

    function bit [7:0] breath(bit [7:0] c, bit [31:0] ramp_ms);
      longint unsigned v;
      v = 64'(c) * 64'(pct) * (64'd4500 + 64'd17 * 64'(ramp_ms));
      return clip(v / 64'd3000000);
    endfunction

    function rgb_t hue_color();
      int unsigned f, up, down;
      rgb_t c;
      f = hue % 60;
      up = f * 255 / 60;
      down = (60 - f) * 255 / 60;
      // packed as {blue, green, red}
      case (hue / 60)
        0: c = {8'd0, up[7:0], 8'd255};
        1: c = {8'd0, 8'd255, down[7:0]};
        2: c = {up[7:0], 8'd255, 8'd0};
        3: c = {8'd255, down[7:0], 8'd0};
        4: c = {8'd255, 8'd0, up[7:0]};
        default: c = {down[7:0], 8'd0, 8'd255};
      endcase
      return {dim(c[2]), dim(c[1]), dim(c[0])};
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_BASE_RED:   base_r = value[7:0];
        REG_BASE_GREEN: base_g = value[7:0];
        REG_BASE_BLUE:  base_b = value[7:0];
        REG_BRIGHTNESS: pct = value[6:0];
        REG_MODE: begin
          mode = value[1:0];
          if (mode == MODE_HUE_SWEEP) hue = '0;
        end
        REG_ENABLE:     lit = value[0];
        default: return;
      endcase
      pending = 1'b1;
    endfunction

    function void note_tick(bit [31:0] now_ms);
      bit [31:0] gap, phase_ms, ramp_ms;
      rgb_t c;
      if (!(lit && (mode == MODE_HUE_SWEEP || mode == MODE_BREATH))) begin
        if (!pending) return;
        pending = 1'b0;
        c = lit ? {dim(base_b), dim(base_g), dim(base_r)} : '0;
        n_static++;
      end else begin
        // elapsed time wraps with the 32 bit counter
        gap = now_ms - last_ms;
        if (gap < FRAME_MS) return;
        last_ms = now_ms;
        if (mode == MODE_HUE_SWEEP) begin
          hue = hue + HUE_STEP;
          if (hue >= HUE_FULL) hue = hue - HUE_FULL;
          c = hue_color();
          n_rainbow++;
        end else begin
          phase_ms = now_ms % 3000;
          ramp_ms = (phase_ms < 1500) ? phase_ms : 3000 - phase_ms;
          c = {breath(base_b, ramp_ms), breath(base_g, ramp_ms), breath(base_r, ramp_ms)};
          n_breath++;
        end
      end
      colors_due.push_back(c);
    endfunction

    function void check_color(rgb_t got);
      rgb_t want;
      string names[3];
      names = '{"red", "green", "blue"};
      if (colors_due.size() == 0) begin
        $display("%0t: color r=%0d g=%0d b=%0d with none expected",
                 $time, got[0], got[1], got[2]);
        mismatches++;
        return;
      end
      want = colors_due.pop_front();
      checked++;
      for (int i = 0; i < 3; i++) begin
        if (got[i] !== want[i]) begin
          $display("%0t: %s mismatch, expected %0d, actual %0d",
                   $time, names[i], want[i], got[i]);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  rgbled_in_if  in_ch ();
  rgbled_out_if out_ch ();

  rgb_led_effect_generator DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  led_color_board board = new();
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned holds_asked   = 0;
  int unsigned idle_cycles   = 0;
  int unsigned ticks_sent    = 0;
  int unsigned reg_writes    = 0;
  bit [31:0]   clock_ms      = '0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // color sink: random stalls plus long hold-offs on request
  initial begin
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left = 0;
    holds_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_color({out_ch.led_blue, out_ch.led_green, out_ch.led_red});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic set_idle(int unsigned src, int unsigned snk);
    src_idle_pct = src;
    snk_stall_pct = snk;
  endtask

  // waits for every owed color, then lets a tick with no result finish
  task automatic settle();
    while (board.colors_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_reg(idx, value);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high across back-to-back transactions unless a random idle gap is drawn
  task automatic send_tick(bit [31:0] now_ms);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.now_ms <= now_ms;
    do @(posedge clk); while (!in_ch.ready);
    board.note_tick(now_ms);
    ticks_sent++;
  endtask

  task automatic send_list(bit [31:0] stamps[$]);
    foreach (stamps[i]) send_tick(stamps[i]);
    in_ch.valid <= 1'b0;
    settle();
  endtask

  task automatic tick_burst(int unsigned count, bit steady);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99, 0);
      if (steady) clock_ms += $urandom_range(60, 30);
      else if (pick < 70) clock_ms += $urandom_range(40, 25);
      else if (pick < 85) clock_ms += $urandom_range(29, 0);
      else if (pick < 95) clock_ms += $urandom_range(3000, 41);
      else clock_ms = $urandom;
      send_tick(clock_ms);
    end
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(3, 0))
      0: return 32'd0;
      1: return 32'd255;
      default: return $urandom_range(255, 0);
    endcase
  endfunction

  task automatic shuffle_regs();
    int unsigned pick;
    logic [31:0] value;
    if ($urandom_range(1, 0)) reg_write(REG_BASE_RED, pick_level());
    if ($urandom_range(1, 0)) reg_write(REG_BASE_GREEN, pick_level());
    if ($urandom_range(1, 0)) reg_write(REG_BASE_BLUE, pick_level());
    if ($urandom_range(2, 0) != 0) begin
      case ($urandom_range(3, 0))
        0: value = 32'd0;
        1: value = 32'd100;
        2: value = 32'd127;
        default: value = $urandom_range(127, 0);
      endcase
      reg_write(REG_BRIGHTNESS, value);
    end
    if ($urandom_range(2, 0) != 0) begin
      pick = $urandom_range(9, 0);
      if (pick < 2) value = MODE_SOLID;
      else if (pick == 2) value = MODE_SPARE;
      else if (pick < 6) value = MODE_HUE_SWEEP;
      else value = MODE_BREATH;
      reg_write(REG_MODE, value);
    end
    if ($urandom_range(1, 0)) reg_write(REG_ENABLE, $urandom_range(99, 0) < 85);
    if ($urandom_range(9, 0) == 0)
      reg_write($urandom_range(1, 0) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
  endtask

  initial begin
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.now_ms = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dark color once after reset, then silence
    send_list('{32'd0, 32'd5});
    reg_write(REG_ENABLE, 32'd1);
    send_list('{32'd100});
    // brightness past 100 saturates
    reg_write(REG_BASE_RED, 32'd0);
    reg_write(REG_BASE_GREEN, 32'd128);
    reg_write(REG_BRIGHTNESS, 32'd127);
    send_list('{32'hFFFF_FFFF});
    reg_write(REG_BRIGHTNESS, 32'd0);
    send_list('{32'd200});
    // unused mode code acts as static
    reg_write(REG_BRIGHTNESS, 32'd100);
    reg_write(REG_MODE, MODE_SPARE);
    send_list('{32'd300, 32'd301});
    // writes outside the map leave nothing pending
    reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_HI, 32'h0000_0001);
    send_list('{32'd400});
    // frame spacing, exactly 30 ms, and time wrapping
    reg_write(REG_MODE, MODE_HUE_SWEEP);
    send_list('{32'd1000, 32'd1029, 32'd1030, 32'hFFFF_FFF0, 32'h0000_000D,
                32'h0000_000E});
    // breathing at the ends and the peak of the triangle
    reg_write(REG_MODE, MODE_BREATH);
    reg_write(REG_BRIGHTNESS, 32'd127);
    reg_write(REG_BASE_RED, 32'd255);
    send_list('{32'd30000, 32'd31499, 32'd34500, 32'd35999, 32'd36028});
    reg_write(REG_ENABLE, 32'd0);
    send_list('{32'd40000});

    // long rainbow run so the hue wraps through every sector, time wraps too
    clock_ms = 32'hFFFF_F000;
    set_idle(9, 9);
    reg_write(REG_ENABLE, 32'd1);
    reg_write(REG_BRIGHTNESS, $urandom_range(100, 60));
    reg_write(REG_MODE, MODE_HUE_SWEEP);
    tick_burst(190, 1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      set_idle(SRC_PCT[p % 4], SNK_PCT[p % 4]);
      shuffle_regs();
      if (p == 4) begin
        // sink holds off while ticks keep coming, so the block backs up
        reg_write(REG_ENABLE, 32'd1);
        reg_write(REG_MODE, MODE_BREATH);
        holds_asked <= holds_asked + 1;
      end
      tick_burst(32, 1'b0);
      settle();
    end

    repeat (40) @(posedge clk);
    $display("covered %0d ticks and %0d register writes, %0d colors checked",
             ticks_sent, reg_writes, board.checked);
    $display("colors by kind: %0d rainbow, %0d breathing, %0d static or dark; %0d mismatches",
             board.n_rainbow, board.n_breath, board.n_static, board.mismatches);
    if (board.mismatches == 0 && board.colors_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
